FILE: sv/rne_pkg.sv
`timescale 1ns / 1ps
// rne_pkg: shared types, constants and helper functions of the roman numeral encoder
// no dependencies; imported by every module of the block

package rne_pkg;

    // widths of the payload fields
    localparam int VALUE_W = 12;
    localparam int GLYPH_W = 7;
    localparam int CFG_DATA_W = 1;
    localparam int CFG_IDX_W = 1;

    // largest value that has a numeral
    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    // depth of the command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ZERO = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_ONES = 1'd1;

    // decimal place indexes
    localparam logic [1:0] PLACE_ONES = 2'd0;
    localparam logic [1:0] PLACE_TENS = 2'd1;
    localparam logic [1:0] PLACE_HUND = 2'd2;
    localparam logic [1:0] PLACE_THOU = 2'd3;

    // ascii codes of the numeral characters
    localparam logic [GLYPH_W-1:0] GLYPH_NONE = 7'h00;
    localparam logic [GLYPH_W-1:0] GLYPH_I = 7'h49;
    localparam logic [GLYPH_W-1:0] GLYPH_V = 7'h56;
    localparam logic [GLYPH_W-1:0] GLYPH_X = 7'h58;
    localparam logic [GLYPH_W-1:0] GLYPH_L = 7'h4C;
    localparam logic [GLYPH_W-1:0] GLYPH_C = 7'h43;
    localparam logic [GLYPH_W-1:0] GLYPH_D = 7'h44;
    localparam logic [GLYPH_W-1:0] GLYPH_M = 7'h4D;
    localparam logic [GLYPH_W-1:0] GLYPH_N = 7'h4E;

    // role of a character within one decimal digit
    typedef enum logic [1:0] {
        SYM_ONE,
        SYM_FIVE,
        SYM_TEN
    } t_sym;

    // front state machine
    typedef enum logic [2:0] {
        F_IDLE,
        F_THOU,
        F_HUND,
        F_TENS,
        F_PUSH
    } t_front_state;

    // back state machine
    typedef enum logic {
        B_IDLE,
        B_EMIT
    } t_back_state;

    // classified request handed from front to back
    typedef struct packed {
        logic       err;
        logic       zero;
        logic       long4;
        logic [1:0] d_th;
        logic [3:0] d_hu;
        logic [3:0] d_te;
        logic [3:0] d_on;
    } t_cmd;

    // one decimal digit split off a remainder
    typedef struct packed {
        logic [3:0]         digit;
        logic [VALUE_W-1:0] rem;
    } t_dec;

    // splits off the digit for one weight with parallel compares
    function automatic t_dec dec_step(input logic [VALUE_W-1:0] rem,
                                      input logic [13:0] weight);
        t_dec        res;
        logic [13:0] sub;
        res.digit = '0;
        sub = '0;
        for (int k = 1; k < 10; k++) begin
            if ({2'b00, rem} >= 14'(k) * weight) begin
                res.digit = 4'(k);
                sub = 14'(k) * weight;
            end
        end
        res.rem = 12'({2'b00, rem} - sub);
        return res;
    endfunction

    // number of characters that one digit takes
    function automatic logic [2:0] digit_len(input logic [3:0] d, input logic long4);
        logic [2:0] len;
        if (d == 4'd9) begin
            len = 3'd2;
        end else if (d == 4'd4 && !long4) begin
            len = 3'd2;
        end else if (d >= 4'd5) begin
            len = 3'(d - 4'd4);
        end else begin
            len = d[2:0];
        end
        return len;
    endfunction

    // role of the character at position k of a digit
    function automatic t_sym digit_sym(input logic [3:0] d, input logic [2:0] k,
                                       input logic long4);
        t_sym s;
        if (d == 4'd9) begin
            s = (k == 3'd0) ? SYM_ONE : SYM_TEN;
        end else if (d == 4'd4 && !long4) begin
            s = (k == 3'd0) ? SYM_ONE : SYM_FIVE;
        end else if (d >= 4'd5) begin
            s = (k == 3'd0) ? SYM_FIVE : SYM_ONE;
        end else begin
            s = SYM_ONE;
        end
        return s;
    endfunction

    // ascii character for a role at a decimal place
    function automatic logic [GLYPH_W-1:0] place_glyph(input logic [1:0] place,
                                                       input t_sym s);
        logic [GLYPH_W-1:0] g;
        unique case (place)
            PLACE_THOU: g = GLYPH_M;
            PLACE_HUND: begin
                unique case (s)
                    SYM_ONE:  g = GLYPH_C;
                    SYM_FIVE: g = GLYPH_D;
                    default:  g = GLYPH_M;
                endcase
            end
            PLACE_TENS: begin
                unique case (s)
                    SYM_ONE:  g = GLYPH_X;
                    SYM_FIVE: g = GLYPH_L;
                    default:  g = GLYPH_C;
                endcase
            end
            default: begin
                unique case (s)
                    SYM_ONE:  g = GLYPH_I;
                    SYM_FIVE: g = GLYPH_V;
                    default:  g = GLYPH_X;
                endcase
            end
        endcase
        return g;
    endfunction

    // digit of a request at a decimal place
    function automatic logic [3:0] digit_of(input t_cmd c, input logic [1:0] place);
        logic [3:0] d;
        unique case (place)
            PLACE_THOU: d = {2'b00, c.d_th};
            PLACE_HUND: d = c.d_hu;
            PLACE_TENS: d = c.d_te;
            default:    d = c.d_on;
        endcase
        return d;
    endfunction

    // mask of places that produce at least one character
    function automatic logic [3:0] place_mask(input t_cmd c);
        logic [3:0] m;
        for (int p = 0; p < 4; p++) begin
            m[p] = (digit_len(digit_of(c, 2'(p)), c.long4 && (p == 0)) != 3'd0);
        end
        return m;
    endfunction

    // index of the highest set bit of a place mask
    function automatic logic [1:0] top_place(input logic [3:0] m);
        logic [1:0] idx;
        idx = PLACE_ONES;
        for (int p = 0; p < 4; p++) begin
            if (m[p]) begin
                idx = 2'(p);
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/roman_numeral_encoder.sv
`timescale 1ns / 1ps
// roman_numeral_encoder: top level, configuration registers and front/queue/back wiring
// depends on rne_pkg, rne_front, rne_cmd_fifo, rne_back
//
// Usage:
//   Input queue: present i_value with push; a request is taken at an edge where
//   push is high and full is low. Results come out as a queue: while empty is
//   low, o_glyph/o_last/o_error show the oldest character; pop takes it.
//   Each value yields its numeral one ASCII character per result, o_last set on
//   the final one; an unencodable value yields one result with o_error set.
//   Config: i_cfg_we writes i_cfg_data[0] to register i_cfg_idx
//   (0 allow_zero, 1 four_ones); write only while the block is idle.
// Timing:
//   The front takes a value, splits off its thousands, hundreds and tens
//   digits one state each (ones are the remainder) and queues the request;
//   full is high from accept until the front is idle again. The back loads
//   a request, then emits one character per cycle while its result slot is
//   free; an error or N is emitted straight from idle. A stalled receiver
//   holds the result register; the back and then the front stop once the
//   request queue fills. Reset empties everything and clears both config
//   registers; no clearing pass.

module roman_numeral_encoder
    import rne_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output logic [GLYPH_W-1:0]    o_glyph,
    output logic                  o_last,
    output logic                  o_error,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic r_allow_zero;
    logic r_four_ones;
    logic cmd_push;
    logic cmd_full;
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd_in;
    t_cmd cmd_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_zero <= 1'b0;
            r_four_ones <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALLOW_ZERO: r_allow_zero <= i_cfg_data[0];
                CFG_FOUR_ONES:  r_four_ones <= i_cfg_data[0];
                default:        r_allow_zero <= r_allow_zero;
            endcase
        end
    end

    // range check and digit split
    rne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_value      (i_value),
        .o_full       (full),
        .i_allow_zero (r_allow_zero),
        .i_four_ones  (r_four_ones),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full)
    );

    // request queue
    rne_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_data  (cmd_out),
        .o_valid (cmd_valid)
    );

    // character emission
    rne_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_glyph     (o_glyph),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

FILE: sv/rne_front.sv
`timescale 1ns / 1ps
// rne_front: accepts values, checks their range and splits them into decimal digits
// depends on rne_pkg

module rne_front
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_full,
    input  logic               i_allow_zero,
    input  logic               i_four_ones,
    output logic               o_cmd_push,
    output t_cmd               o_cmd,
    input  logic               i_cmd_full
);

    t_front_state       r_state;
    t_front_state       n_state;
    logic [VALUE_W-1:0] r_rem;
    logic               r_err;
    logic               r_zero;
    logic               r_long4;
    logic [1:0]         r_d_th;
    logic [3:0]         r_d_hu;
    logic [3:0]         r_d_te;
    logic [13:0]        step_weight;
    t_dec               step;
    logic               accept;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push) n_state = F_THOU;
            F_THOU: n_state = F_HUND;
            F_HUND: n_state = F_TENS;
            F_TENS: n_state = F_PUSH;
            F_PUSH: if (!i_cmd_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_full = 1'b1;
        o_cmd_push = 1'b0;
        step_weight = 14'd1000;
        unique case (r_state)
            F_IDLE: o_full = 1'b0;
            F_THOU: step_weight = 14'd1000;
            F_HUND: step_weight = 14'd100;
            F_TENS: step_weight = 14'd10;
            F_PUSH: o_cmd_push = 1'b1;
            default: o_full = 1'b1;
        endcase
    end

    assign accept = i_push && !o_full;
    assign step = dec_step(r_rem, step_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // classify on accept, then one digit per cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rem <= i_value;
            r_err <= (i_value > MAX_VALUE) || (i_value == '0 && !i_allow_zero);
            r_zero <= (i_value == '0);
            r_long4 <= i_four_ones;
        end else if (r_state == F_THOU) begin
            r_d_th <= step.digit[1:0];
            r_rem <= step.rem;
        end else if (r_state == F_HUND) begin
            r_d_hu <= step.digit;
            r_rem <= step.rem;
        end else if (r_state == F_TENS) begin
            r_d_te <= step.digit;
            r_rem <= step.rem;
        end
    end

    // request to the back
    always_comb begin
        o_cmd.err = r_err;
        o_cmd.zero = r_zero;
        o_cmd.long4 = r_long4;
        o_cmd.d_th = r_d_th;
        o_cmd.d_hu = r_d_hu;
        o_cmd.d_te = r_d_te;
        o_cmd.d_on = r_rem[3:0];
    end

endmodule

FILE: sv/rne_cmd_fifo.sv
`timescale 1ns / 1ps
// rne_cmd_fifo: short request queue between front and back
// depends on rne_pkg

module rne_cmd_fifo
    import rne_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_rd,
    output t_cmd o_data,
    output logic o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && o_valid;
    assign o_data = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/rne_back.sv
`timescale 1ns / 1ps
// rne_back: walks a request's digits and emits one numeral character per cycle while its result slot is free
// depends on rne_pkg

module rne_back
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [GLYPH_W-1:0] o_glyph,
    output logic               o_last,
    output logic               o_error
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    logic [1:0]         r_place;
    logic [2:0]         r_pos;
    logic               r_out_valid;
    logic [GLYPH_W-1:0] r_glyph;
    logic               r_last;
    logic               r_err;

    logic               slot_free;
    logic [3:0]         cur_digit;
    logic               cur_long4;
    logic [2:0]         cur_len;
    logic [3:0]         cur_mask;
    logic [3:0]         lower_mask;
    logic               end_digit;
    logic               done;
    logic               load;
    logic               emit;
    logic [GLYPH_W-1:0] emit_glyph;
    logic               emit_last;
    logic               emit_err;

    assign slot_free = !r_out_valid || i_pop;

    // current character and what follows it
    assign cur_digit = digit_of(r_cmd, r_place);
    assign cur_long4 = r_cmd.long4 && (r_place == PLACE_ONES);
    assign cur_len = digit_len(cur_digit, cur_long4);
    assign cur_mask = place_mask(r_cmd);
    assign lower_mask = cur_mask & ((4'd1 << r_place) - 4'd1);
    assign end_digit = (r_pos + 3'd1 == cur_len);
    assign done = end_digit && (lower_mask == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && slot_free && !i_cmd.err && !i_cmd.zero) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: if (slot_free && done) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        load = 1'b0;
        emit = 1'b0;
        emit_glyph = GLYPH_NONE;
        emit_last = 1'b0;
        emit_err = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && slot_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.err) begin
                        emit = 1'b1;
                        emit_last = 1'b1;
                        emit_err = 1'b1;
                    end else if (i_cmd.zero) begin
                        emit = 1'b1;
                        emit_glyph = GLYPH_N;
                        emit_last = 1'b1;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            B_EMIT: begin
                emit = slot_free;
                emit_glyph = place_glyph(r_place, digit_sym(cur_digit, r_pos, cur_long4));
                emit_last = done;
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // walk position: start at the highest place that has characters
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
            r_place <= top_place(place_mask(i_cmd));
            r_pos <= '0;
        end else if (r_state == B_EMIT && slot_free) begin
            if (end_digit) begin
                r_place <= top_place(lower_mask);
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (slot_free && emit) begin
            r_glyph <= emit_glyph;
            r_last <= emit_last;
            r_err <= emit_err;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_glyph = r_glyph;
    assign o_last = r_last;
    assign o_error = r_err;

endmodule

FILE: sv/rne_checker.sv
`timescale 1ns / 1ps
// rne_checker: port-level assertions for the roman numeral encoder, bound to the top level
// depends on rne_pkg and roman_numeral_encoder

module rne_checker
    import rne_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic [GLYPH_W-1:0] o_glyph,
    input logic               o_last,
    input logic               o_error
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // an error result is a lone blank character
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_glyph == GLYPH_NONE && o_last))
        else $error("error result not blank and last");

    // a normal result is a numeral character
    a_glyph_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_error) |-> (o_glyph == GLYPH_I || o_glyph == GLYPH_V ||
            o_glyph == GLYPH_X || o_glyph == GLYPH_L || o_glyph == GLYPH_C ||
            o_glyph == GLYPH_D || o_glyph == GLYPH_M || o_glyph == GLYPH_N))
        else $error("result character outside numeral set");

    // zero's character ends its run
    a_zero_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_glyph == GLYPH_N) |-> o_last)
        else $error("N not marked last");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_glyph) && $stable(o_last)
            && $stable(o_error)))
        else $error("stalled result changed");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);

FILE: test/rne_checker.sv
`timescale 1ns / 1ps
// rne_tb_checker: watches the request and result queues of the roman numeral encoder,
// predicts the character run of each accepted value and compares every result
// depends on rne_pkg for widths, register indexes and character codes

module rne_tb_checker
    import rne_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [GLYPH_W-1:0]    i_glyph,
    input  logic                  i_last,
    input  logic                  i_error,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // one character of a numeral run
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               last;
        logic               error;
    } t_numeral_char;

    t_numeral_char chars_due[$];
    logic          allow_zero_q;
    logic          four_ones_q;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        allow_zero_q = 1'b0;
        four_ones_q = 1'b0;
    end

    // print one line per mismatch and count it
    task automatic report_mismatch(input string note, input t_numeral_char got,
                                   input t_numeral_char want);
        $display("%0t %s: got glyph %02h last %b error %b, want glyph %02h last %b error %b",
                 $time, note, got.glyph, got.last, got.error,
                 want.glyph, want.last, want.error);
        o_fail_count++;
    endtask

    function automatic void add_char(input logic [GLYPH_W-1:0] g);
        t_numeral_char c;
        c.glyph = g;
        c.last = 1'b0;
        c.error = 1'b0;
        chars_due.insert(chars_due.size(), c);
    endfunction

    // one decimal digit from its one, five and ten signs
    function automatic void add_digit(input int d, input logic [GLYPH_W-1:0] one,
                                      input logic [GLYPH_W-1:0] five,
                                      input logic [GLYPH_W-1:0] ten, input logic long4);
        int rest;
        rest = d;
        if (d == 9) begin
            add_char(one);
            add_char(ten);
        end else if (d == 4 && !long4) begin
            add_char(one);
            add_char(five);
        end else begin
            if (rest >= 5) begin
                add_char(five);
                rest -= 5;
            end
            for (int k = 0; k < rest; k++) begin
                add_char(one);
            end
        end
    endfunction

    // queue the expected run of characters for one value
    function automatic void spell_numeral(input logic [VALUE_W-1:0] value);
        int v;
        v = int'(value);
        if (v >= 1 && v <= int'(MAX_VALUE)) begin
            for (int k = 0; k < v / 1000; k++) begin
                add_char(GLYPH_M);
            end
            add_digit((v / 100) % 10, GLYPH_C, GLYPH_D, GLYPH_M, 1'b0);
            add_digit((v / 10) % 10, GLYPH_X, GLYPH_L, GLYPH_C, 1'b0);
            add_digit(v % 10, GLYPH_I, GLYPH_V, GLYPH_X, four_ones_q);
            chars_due[$].last = 1'b1;
        end else if (v == 0 && allow_zero_q) begin
            add_char(GLYPH_N);
            chars_due[$].last = 1'b1;
        end else begin
            add_char(GLYPH_NONE);
            chars_due[$].last = 1'b1;
            chars_due[$].error = 1'b1;
        end
    endfunction

    // config mirror, result compare, then prediction of the new request
    always @(posedge i_clk) begin : watch_proc
        t_numeral_char got;
        t_numeral_char want;
        if (!i_rst_n) begin
            allow_zero_q = 1'b0;
            four_ones_q = 1'b0;
            chars_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALLOW_ZERO: allow_zero_q = i_cfg_data[0];
                    CFG_FOUR_ONES:  four_ones_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                got = '{glyph: i_glyph, last: i_last, error: i_error};
                if (chars_due.size() == 0) begin
                    report_mismatch("result with nothing expected", got, '0);
                end else begin
                    want = chars_due.pop_front();
                    if (got !== want) begin
                        report_mismatch("wrong character", got, want);
                    end
                end
            end
            if (push && !full) begin
                spell_numeral(i_value);
            end
        end
        o_pending <= chars_due.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: drives values and register writes into the roman numeral encoder,
// pops its characters and gives the verdict from the checker's failure count
// depends on rne_pkg, roman_numeral_encoder and rne_tb_checker

module testbench;
    import rne_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 46;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic [VALUE_W-1:0]    i_value = '0;
    logic                  pop = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_ALLOW_ZERO;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  full;
    logic                  empty;
    logic [GLYPH_W-1:0]    o_glyph;
    logic                  o_last;
    logic                  o_error;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_on = 1'b0;
    int   idle_cycles = 0;
    event hold_off_ev;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    roman_numeral_encoder dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_value   (i_value),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .o_glyph   (o_glyph),
        .o_last    (o_last),
        .o_error   (o_error),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    rne_tb_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .i_glyph     (o_glyph),
        .i_last      (o_last),
        .i_error     (o_error),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    always begin
        @(hold_off_ev);
        hold_on <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // watchdog on cycles with no request or result taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[roman_numeral_encoder] ERROR");
            $finish;
        end
    end

    // one register write, then a wait with the write enable low before returning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one value after a random gap; returns at the edge that takes it
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // stop offering until every expected character has come out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly valid numbers, with zeros, out-of-range values and long runs mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) begin
            return '0;
        end else if (sel < 14) begin
            return VALUE_W'($urandom_range(4095, 4000));
        end else if (sel < 26) begin
            return VALUE_W'($urandom_range(399, 0) * 10 + ($urandom_range(1) ? 4 : 9));
        end else if (sel < 36) begin
            return VALUE_W'($urandom_range(40, 1));
        end else if (sel < 42) begin
            return VALUE_W'($urandom_range(3, 0) * 1000 + 888);
        end
        return VALUE_W'($urandom_range(3999, 1));
    endfunction

    initial begin
        int plain_vals[$];
        int option_vals[$];
        plain_vals = '{0, 1, 4, 9, 5, 14, 40, 49, 90, 400, 444, 900, 949, 1000,
                       3888, 3999, 4000, 4095};
        option_vals = '{0, 4, 14, 444, 3994, 4095};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed values at reset settings, then with both options on
        foreach (plain_vals[k]) send_value(VALUE_W'(plain_vals[k]));
        wait_drained();
        write_reg(CFG_ALLOW_ZERO, 1'b1);
        write_reg(CFG_FOUR_ONES, 1'b1);
        foreach (option_vals[k]) send_value(VALUE_W'(option_vals[k]));
        wait_drained();

        // random phases across settings and idling patterns
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_ALLOW_ZERO, (p % 2) != 0);
            write_reg(CFG_FOUR_ONES, (p / 2) != 0);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 66; end
                default: begin send_idle_pct = 34; recv_stall_pct <= 34; end
            endcase
            // receiver holds off while the sender keeps offering
            if (p == 0) -> hold_off_ev;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_value(pick_value());
                if (n == PHASE_ITEMS / 2) wait_drained();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[roman_numeral_encoder] OK");
        end else begin
            $display("[roman_numeral_encoder] ERROR");
        end
        $finish;
    end

endmodule
